FILE: src/jrmr_pkg.sv
package jrmr_pkg;

	localparam int QueueDepth = 4;

	localparam logic [2:0] ACT_START = 3'd0;
	localparam logic [2:0] ACT_HUNT  = 3'd1;
	localparam logic [2:0] ACT_BYTE  = 3'd2;
	localparam logic [2:0] ACT_EOF   = 3'd3;
	localparam logic [2:0] ACT_EMIT  = 3'd4;

	localparam logic [3:0] KIND_RST_OK     = 4'd0;
	localparam logic [3:0] KIND_LOST       = 4'd1;
	localparam logic [3:0] KIND_DNL_OK     = 4'd2;
	localparam logic [3:0] KIND_DNL_SEEN   = 4'd3;
	localparam logic [3:0] KIND_DNL_LENGTH = 4'd4;
	localparam logic [3:0] KIND_ZERO_HT    = 4'd5;
	localparam logic [3:0] KIND_DNL_TRUNC  = 4'd6;
	localparam logic [3:0] KIND_EOF        = 4'd7;
	localparam logic [3:0] KIND_MARKER     = 4'd8;

	localparam logic [7:0] BYTE_FILL   = 8'hFF;
	localparam logic [7:0] BYTE_DNL    = 8'hDC;
	localparam logic [4:0] RST_PREFIX  = 5'h1A;
	localparam logic [15:0] DNL_LENGTH = 16'd4;

	localparam logic [1:0] LEFT_MARKER = 2'd2;

	// one queue entry; dual marks the two-byte marker emission
	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  next_index;
		logic        segment_valid;
		logic        resynced;
		logic [15:0] frame_height;
		logic [1:0]  bytes_left;
		logic [7:0]  out_byte;
		logic        dual;
	} res_t;

endpackage

FILE: src/jrmr_front.sv
module jrmr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              scan_for_dnl,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [2:0]        action,
	input  logic [7:0]        stream_byte,
	input  logic              q_full,
	output logic              q_push,
	output jrmr_pkg::res_t    q_data
);
	import jrmr_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_BOUND  = 3'd1;
	localparam logic [2:0] PH_HUNT   = 3'd2;
	localparam logic [2:0] PH_DNL_LH = 3'd3;
	localparam logic [2:0] PH_DNL_LL = 3'd4;
	localparam logic [2:0] PH_DNL_HH = 3'd5;
	localparam logic [2:0] PH_DNL_HL = 3'd6;

	logic [2:0] exp_q, exp_d;
	logic [2:0] phase_q, phase_d;
	logic       saw_q, saw_d;
	logic       oos_q, oos_d;
	logic       dnl_q, dnl_d;
	logic       seg_q, seg_d;
	logic [7:0] fhi_q, fhi_d;

	logic        accept;
	logic        hw, acc, lose, err;
	logic [3:0]  err_kind;
	logic [3:0]  r_kind;
	logic [1:0]  r_left;
	logic [15:0] r_height;
	logic [7:0]  r_ob;
	logic        r_dual;
	logic        push;
	logic [15:0] word;
	logic [2:0]  idx_diff;
	logic        is_rst, is_marker;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;

	assign word      = {fhi_q, stream_byte};
	assign idx_diff  = stream_byte[2:0] - exp_q;
	assign is_rst    = stream_byte[7:3] == RST_PREFIX;
	assign is_marker = stream_byte[7:6] == 2'b11 && stream_byte[5:4] != 2'b11;

	always_comb begin
		exp_d = exp_q;
		phase_d = phase_q;
		saw_d = saw_q;
		oos_d = oos_q;
		dnl_d = dnl_q;
		seg_d = seg_q;
		fhi_d = fhi_q;
		push = 1'b0;
		hw = 1'b0;
		acc = 1'b0;
		lose = 1'b0;
		err = 1'b0;
		err_kind = KIND_EOF;
		r_kind = KIND_RST_OK;
		r_left = '0;
		r_height = '0;
		r_ob = '0;
		r_dual = 1'b0;
		if (accept) begin
			unique case (action)
				ACT_START: begin
					exp_d = '0;
					phase_d = PH_IDLE;
					saw_d = 1'b0;
					oos_d = 1'b0;
					dnl_d = 1'b0;
					seg_d = 1'b1;
					fhi_d = '0;
				end
				ACT_HUNT: begin
					phase_d = PH_BOUND;
					saw_d = 1'b0;
					oos_d = 1'b0;
				end
				ACT_BYTE: begin
					unique case (phase_q)
						PH_BOUND: begin
							if (!saw_q) begin
								if (stream_byte == BYTE_FILL) begin
									saw_d = 1'b1;
								end else begin
									oos_d = 1'b1;
									phase_d = PH_HUNT;
								end
							end else if (stream_byte == BYTE_FILL) begin
								saw_d = 1'b1;
							end else if (stream_byte == BYTE_DNL && scan_for_dnl) begin
								saw_d = 1'b0;
								if (dnl_q) begin
									phase_d = PH_IDLE;
									push = 1'b1;
									r_kind = KIND_DNL_SEEN;
									r_left = LEFT_MARKER;
								end else begin
									phase_d = PH_DNL_LH;
								end
							end else if (stream_byte == {RST_PREFIX, exp_q}) begin
								acc = 1'b1;
							end else begin
								oos_d = 1'b1;
								phase_d = PH_HUNT;
								hw = 1'b1;
							end
						end
						PH_HUNT: begin
							if (!saw_q) begin
								if (stream_byte == BYTE_FILL) begin
									saw_d = 1'b1;
								end
							end else begin
								hw = 1'b1;
							end
						end
						PH_DNL_LH: begin
							fhi_d = stream_byte;
							phase_d = PH_DNL_LL;
						end
						PH_DNL_LL: begin
							fhi_d = stream_byte;
							if (word != DNL_LENGTH) begin
								err = 1'b1;
								err_kind = KIND_DNL_LENGTH;
							end else begin
								phase_d = PH_DNL_HH;
							end
						end
						PH_DNL_HH: begin
							fhi_d = stream_byte;
							phase_d = PH_DNL_HL;
						end
						PH_DNL_HL: begin
							fhi_d = stream_byte;
							if (word == '0) begin
								err = 1'b1;
								err_kind = KIND_ZERO_HT;
							end else begin
								dnl_d = 1'b1;
								phase_d = PH_IDLE;
								push = 1'b1;
								r_kind = KIND_DNL_OK;
								r_height = word;
							end
						end
						default: ;
					endcase
				end
				ACT_EOF: begin
					unique case (phase_q)
						PH_BOUND, PH_HUNT: begin
							err = 1'b1;
							err_kind = KIND_EOF;
						end
						PH_DNL_LH, PH_DNL_LL: begin
							err = 1'b1;
							err_kind = KIND_DNL_LENGTH;
						end
						PH_DNL_HH, PH_DNL_HL: begin
							err = 1'b1;
							err_kind = KIND_DNL_TRUNC;
						end
						default: ;
					endcase
				end
				ACT_EMIT: begin
					push = 1'b1;
					r_dual = 1'b1;
					r_kind = KIND_MARKER;
					r_ob = {RST_PREFIX, exp_q};
					exp_d = exp_q + 3'd1;
				end
				default: ;
			endcase
		end
		// word 0xff b seen while hunting
		if (hw) begin
			if (stream_byte == BYTE_FILL) begin
				saw_d = 1'b1;
			end else if (is_rst) begin
				if (stream_byte[2:0] == exp_q) begin
					acc = 1'b1;
				end else if (idx_diff[2]) begin
					saw_d = 1'b0;
				end else begin
					lose = 1'b1;
				end
			end else if (is_marker) begin
				lose = 1'b1;
			end else begin
				saw_d = 1'b0;
			end
		end
		if (acc) begin
			exp_d = exp_q + 3'd1;
			seg_d = 1'b1;
			phase_d = PH_IDLE;
			saw_d = 1'b0;
			push = 1'b1;
			r_kind = KIND_RST_OK;
		end
		if (lose) begin
			exp_d = exp_q + 3'd1;
			seg_d = 1'b0;
			phase_d = PH_IDLE;
			saw_d = 1'b0;
			push = 1'b1;
			r_kind = KIND_LOST;
			r_left = LEFT_MARKER;
		end
		if (err) begin
			phase_d = PH_IDLE;
			saw_d = 1'b0;
			push = 1'b1;
			r_kind = err_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			phase_q <= PH_IDLE;
			saw_q <= 1'b0;
			oos_q <= 1'b0;
			dnl_q <= 1'b0;
			seg_q <= 1'b1;
			fhi_q <= '0;
		end else begin
			exp_q <= exp_d;
			phase_q <= phase_d;
			saw_q <= saw_d;
			oos_q <= oos_d;
			dnl_q <= dnl_d;
			seg_q <= seg_d;
			fhi_q <= fhi_d;
		end
	end

	assign q_push = push;
	always_comb begin
		q_data.kind = r_kind;
		q_data.next_index = exp_d;
		q_data.segment_valid = seg_d;
		q_data.resynced = oos_d;
		q_data.frame_height = r_height;
		q_data.bytes_left = r_left;
		q_data.out_byte = r_ob;
		q_data.dual = r_dual;
	end

endmodule

FILE: src/jrmr_queue.sv
module jrmr_queue #(
	parameter int DEPTH = jrmr_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jrmr_pkg::res_t    push_data,
	input  logic              pop,
	output jrmr_pkg::res_t    head,
	output logic              empty,
	output logic              full
);
	import jrmr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
	localparam logic [CW-1:0] Full = CW'(DEPTH);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == Full;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
`endif

endmodule

FILE: src/jrmr_back.sv
module jrmr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  jrmr_pkg::res_t    head,
	input  logic              empty,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [3:0]        kind,
	output logic [2:0]        next_index,
	output logic              segment_valid,
	output logic              resynced,
	output logic [15:0]       frame_height,
	output logic [1:0]        bytes_left,
	output logic [7:0]        out_byte,
	output logic              last
);
	import jrmr_pkg::*;

	logic        valid_q;
	logic        half_q;
	logic        load;
	logic        first;
	logic [3:0]  kind_q;
	logic [2:0]  idx_q;
	logic        seg_q;
	logic        oos_q;
	logic [15:0] ht_q;
	logic [1:0]  left_q;
	logic [7:0]  ob_q;
	logic        last_q;

	assign load  = !valid_q || !result_stall;
	// first byte of a marker emission is shown before the entry leaves the queue
	assign first = head.dual && !half_q;
	assign pop   = load && !empty && !first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				half_q <= first;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			kind_q <= head.kind;
			seg_q <= head.segment_valid;
			oos_q <= head.resynced;
			ht_q <= head.frame_height;
			left_q <= head.bytes_left;
			if (first) begin
				idx_q <= head.next_index - 3'd1;
				ob_q <= BYTE_FILL;
				last_q <= 1'b0;
			end else begin
				idx_q <= head.next_index;
				ob_q <= head.out_byte;
				last_q <= 1'b1;
			end
		end
	end

	assign result_valid  = valid_q;
	assign kind          = kind_q;
	assign next_index    = idx_q;
	assign segment_valid = seg_q;
	assign resynced      = oos_q;
	assign frame_height  = ht_q;
	assign bytes_left    = left_q;
	assign out_byte      = ob_q;
	assign last          = last_q;

`ifndef ASSERT_OFF
	a_first_is_marker: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |-> kind_q == KIND_MARKER && ob_q == BYTE_FILL)
		else $error("non-final result is not a marker fill byte");
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q && !result_stall |=> valid_q && last_q && kind_q == KIND_MARKER)
		else $error("marker second byte did not follow");
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q && !result_stall |=> idx_q == $past(idx_q) + 3'd1)
		else $error("marker index did not advance");
`endif

endmodule

FILE: src/jpeg_restart_marker_resync.sv
// JPEG restart marker resynchronizer. Takes one action per transfer on the item
// channel (start scan, begin hunt, stream byte, end of stream, emit marker) and
// returns result transfers on the result channel. An action is taken every cycle
// unless the four-entry result queue is full; a marker emission yields two
// results, a fill byte and then the marker byte, every other action at most one;
// results leave at one per cycle, while result_stall is low, from a registered
// output stage fed by the queue. The DNL enable bit is register 0 of the APB port
// and the user must write it only while the block is idle; it is not enforced.
module jpeg_restart_marker_resync #(
	parameter int QDEPTH = jrmr_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  stream_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  kind,
	output logic [2:0]  next_index,
	output logic        segment_valid,
	output logic        resynced,
	output logic [15:0] frame_height,
	output logic [1:0]  bytes_left,
	output logic [7:0]  out_byte,
	output logic        last
);
	import jrmr_pkg::*;

	logic scan_q;
	logic q_push, q_pop, q_empty, q_full;
	res_t q_in, q_head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'b0, scan_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			scan_q <= pwdata[0];
		end
	end

	jrmr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_for_dnl (scan_q),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.stream_byte  (stream_byte),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	jrmr_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	jrmr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.empty         (q_empty),
		.pop           (q_pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.next_index    (next_index),
		.segment_valid (segment_valid),
		.resynced      (resynced),
		.frame_height  (frame_height),
		.bytes_left    (bytes_left),
		.out_byte      (out_byte),
		.last          (last)
	);

endmodule

FILE: bench/tb_top.sv
module tb_top;
	import jrmr_pkg::*;

	localparam int RUN_LIMIT = 300000;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS = 175;
	localparam logic [2:0] CFG_DNL_ADDR = 3'd0;
	localparam logic [7:0] MARKER_LO = 8'hC0;
	localparam logic [7:0] MARKER_HI = 8'hF0;

	typedef enum logic [3:0] {
		SEEK_IDLE,
		SEEK_BOUNDARY,
		SEEK_HUNT,
		DNL_LEN_HI,
		DNL_LEN_LO,
		DNL_HT_HI,
		DNL_HT_LO
	} seek_phase_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  next_index;
		logic        segment_valid;
		logic        resynced;
		logic [15:0] frame_height;
		logic [1:0]  bytes_left;
		logic [7:0]  out_byte;
		logic        last;
	} restart_result_t;

	class restart_scoreboard;
		bit dnl_en;
		logic [2:0] exp_idx;
		seek_phase_t phase;
		bit saw_ff;
		bit oos;
		bit dnl_seen;
		bit seg_ok;
		logic [15:0] field_word;
		restart_result_t pending[$];
		int errors;

		function new();
			dnl_en = 1'b0;
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			exp_idx = 3'd0;
			phase = SEEK_IDLE;
			saw_ff = 1'b0;
			oos = 1'b0;
			dnl_seen = 1'b0;
			seg_ok = 1'b1;
			field_word = 16'h0000;
		endfunction

		function void expect_res(logic [3:0] k, logic [1:0] left, logic [15:0] ht,
			logic [7:0] ob, logic lst);
			restart_result_t r;
			r.kind = k;
			r.next_index = exp_idx;
			r.segment_valid = seg_ok;
			r.resynced = oos;
			r.frame_height = ht;
			r.bytes_left = left;
			r.out_byte = ob;
			r.last = lst;
			pending.push_back(r);
		endfunction

		function void close_segment(bit lost);
			exp_idx = exp_idx + 3'd1;
			seg_ok = !lost;
			phase = SEEK_IDLE;
			saw_ff = 1'b0;
			if (lost) begin
				expect_res(KIND_LOST, LEFT_MARKER, 16'h0000, 8'h00, 1'b1);
			end else begin
				expect_res(KIND_RST_OK, 2'd0, 16'h0000, 8'h00, 1'b1);
			end
		endfunction

		function void abort_scan(logic [3:0] k);
			phase = SEEK_IDLE;
			saw_ff = 1'b0;
			expect_res(k, 2'd0, 16'h0000, 8'h00, 1'b1);
		endfunction

		// second byte of an 0xFF-prefixed word while hunting
		function void classify_marker(logic [7:0] b);
			logic [2:0] ahead;
			ahead = b[2:0] - exp_idx;
			if (b == BYTE_FILL) begin
				return;
			end
			if (b[7:3] == RST_PREFIX) begin
				if (ahead == 3'd0) close_segment(1'b0);
				else if (ahead >= 3'd4) saw_ff = 1'b0;
				else close_segment(1'b1);
			end else if (b >= MARKER_LO && b < MARKER_HI) begin
				close_segment(1'b1);
			end else begin
				saw_ff = 1'b0;
			end
		endfunction

		function void take_byte(logic [7:0] b);
			case (phase)
				SEEK_BOUNDARY: begin
					if (!saw_ff) begin
						if (b == BYTE_FILL) begin
							saw_ff = 1'b1;
						end else begin
							oos = 1'b1;
							phase = SEEK_HUNT;
						end
					end else if (b == BYTE_FILL) begin
					end else if (b == BYTE_DNL && dnl_en) begin
						saw_ff = 1'b0;
						if (dnl_seen) begin
							phase = SEEK_IDLE;
							expect_res(KIND_DNL_SEEN, LEFT_MARKER, 16'h0000, 8'h00, 1'b1);
						end else begin
							phase = DNL_LEN_HI;
						end
					end else if (b == {RST_PREFIX, exp_idx}) begin
						close_segment(1'b0);
					end else begin
						oos = 1'b1;
						phase = SEEK_HUNT;
						classify_marker(b);
					end
				end
				SEEK_HUNT: begin
					if (!saw_ff) begin
						if (b == BYTE_FILL) saw_ff = 1'b1;
					end else begin
						classify_marker(b);
					end
				end
				DNL_LEN_HI: begin
					field_word = {b, 8'h00};
					phase = DNL_LEN_LO;
				end
				DNL_LEN_LO: begin
					field_word[7:0] = b;
					if (field_word != DNL_LENGTH) abort_scan(KIND_DNL_LENGTH);
					else phase = DNL_HT_HI;
				end
				DNL_HT_HI: begin
					field_word = {b, 8'h00};
					phase = DNL_HT_LO;
				end
				DNL_HT_LO: begin
					field_word[7:0] = b;
					if (field_word == 16'h0000) begin
						abort_scan(KIND_ZERO_HT);
					end else begin
						dnl_seen = 1'b1;
						phase = SEEK_IDLE;
						expect_res(KIND_DNL_OK, 2'd0, field_word, 8'h00, 1'b1);
					end
				end
				default: begin
				end
			endcase
		endfunction

		// returns 0 when the block ignores the transfer
		function bit note_item(logic [2:0] a, logic [7:0] b);
			logic [2:0] idx;
			idx = exp_idx;
			case (a)
				ACT_START: begin
					clear_scan();
					return 1'b1;
				end
				ACT_HUNT: begin
					phase = SEEK_BOUNDARY;
					saw_ff = 1'b0;
					oos = 1'b0;
					return 1'b1;
				end
				ACT_BYTE: begin
					if (phase == SEEK_IDLE) return 1'b0;
					take_byte(b);
					return 1'b1;
				end
				ACT_EOF: begin
					case (phase)
						SEEK_BOUNDARY, SEEK_HUNT: abort_scan(KIND_EOF);
						DNL_LEN_HI, DNL_LEN_LO: abort_scan(KIND_DNL_LENGTH);
						DNL_HT_HI, DNL_HT_LO: abort_scan(KIND_DNL_TRUNC);
						default: return 1'b0;
					endcase
					return 1'b1;
				end
				ACT_EMIT: begin
					expect_res(KIND_MARKER, 2'd0, 16'h0000, BYTE_FILL, 1'b0);
					exp_idx = exp_idx + 3'd1;
					expect_res(KIND_MARKER, 2'd0, 16'h0000, {RST_PREFIX, idx}, 1'b1);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function string show(restart_result_t r);
			return $sformatf("kind=%0d idx=%0d segv=%0b resync=%0b ht=%h left=%0d byte=%h last=%0b",
				r.kind, r.next_index, r.segment_valid, r.resynced, r.frame_height,
				r.bytes_left, r.out_byte, r.last);
		endfunction

		function void check_result(restart_result_t got);
			restart_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transfer: %s", show(got));
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("result mismatch: expected %s", show(want));
					$display("                 actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [2:0] action = 3'd0;
	logic [7:0] stream_byte = 8'h00;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [3:0] kind;
	logic [2:0] next_index;
	logic segment_valid;
	logic resynced;
	logic [15:0] frame_height;
	logic [1:0] bytes_left;
	logic [7:0] out_byte;
	logic last;

	restart_scoreboard sb;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int fed_items = 0;

	jpeg_restart_marker_resync DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.stream_byte(stream_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.next_index(next_index),
		.segment_valid(segment_valid),
		.resynced(resynced),
		.frame_height(frame_height),
		.bytes_left(bytes_left),
		.out_byte(out_byte),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(restart_result_t'{kind, next_index, segment_valid, resynced,
				frame_height, bytes_left, out_byte, last});
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// result side stalls
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else if (arst_n && idle_on && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [2:0] a, input logic [7:0] b);
		item_valid <= 1'b1;
		action <= a;
		stream_byte <= b;
		do @(posedge clk); while (item_stall);
		if (sb.note_item(a, b)) fed_items++;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(ACT_BYTE, b);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dnl_enable(input logic en);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_DNL_ADDR;
		pwdata <= {31'($urandom), en};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.dnl_en = en;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic dnl_body();
		logic [15:0] len;
		logic [15:0] ht;
		logic [7:0] fields[4];
		int cut;
		len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : DNL_LENGTH;
		ht = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
		fields = '{len[15:8], len[7:0], ht[15:8], ht[7:0]};
		send_byte(BYTE_DNL);
		for (int i = 0; i < 4; i++) begin
			if (i == cut) begin
				send_item(ACT_EOF, 8'($urandom));
				break;
			end
			send_byte(fields[i]);
		end
	endtask

	task automatic random_segment();
		int r;
		logic [2:0] far_idx;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			send_item(ACT_START, 8'($urandom));
		end else if (r < 14) begin
			send_item(ACT_EMIT, 8'($urandom));
		end else if (r < 22) begin
			send_item(3'($urandom), 8'($urandom));
		end else begin
			send_item(ACT_HUNT, 8'($urandom));
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
				if ($urandom_range(0, 2) == 0) begin
					far_idx = sb.exp_idx + 3'(4 + $urandom_range(0, 3));
					send_byte(BYTE_FILL);
					send_byte({RST_PREFIX, far_idx});
				end
			end
			repeat ($urandom_range(1, 3)) send_byte(BYTE_FILL);
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_byte({RST_PREFIX, sb.exp_idx});
			end else if (r < 65) begin
				send_byte({RST_PREFIX, 3'($urandom)});
			end else if (r < 82) begin
				dnl_body();
			end else if (r < 92) begin
				send_byte(8'($urandom));
				if ($urandom_range(0, 1) == 0) send_item(ACT_EOF, 8'($urandom));
			end else begin
				send_item(ACT_EOF, 8'($urandom));
			end
		end
	endtask

	initial begin
		int target;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_dnl_enable(1'b0);
		// ignored while idle, and undefined actions
		send_byte(8'h00);
		send_item(ACT_EOF, 8'hFF);
		send_item(3'd7, 8'hFF);
		send_item(3'd5, 8'h00);
		// fill bytes, then the expected marker
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_FILL);
		send_byte(8'hD0);
		send_item(ACT_EMIT, 8'h00);
		// data dropped, far marker consumed, near marker loses the segment
		send_item(ACT_HUNT, 8'h00);
		send_byte(8'h00);
		send_byte(BYTE_FILL);
		send_byte(8'hD6);
		send_byte(BYTE_FILL);
		send_byte(8'hD3);
		// dnl marker with scanning off
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_DNL);
		send_item(ACT_HUNT, 8'h00);
		send_item(ACT_EOF, 8'h00);
		settle();

		write_dnl_enable(1'b1);
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_DNL);
		send_byte(8'h00);
		send_byte(8'h04);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_DNL);
		send_item(ACT_START, 8'h00);
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_DNL);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_DNL);
		send_byte(8'h00);
		send_byte(8'h04);
		send_byte(8'h00);
		send_byte(8'h00);
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_DNL);
		send_byte(8'h00);
		send_item(ACT_EOF, 8'h00);
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_DNL);
		send_byte(8'h00);
		send_byte(8'h04);
		send_byte(8'h12);
		send_item(ACT_EOF, 8'h00);
		send_item(ACT_HUNT, 8'h00);
		send_byte(BYTE_FILL);
		send_byte(8'hE0);
		send_item(ACT_HUNT, 8'h00);
		send_byte(8'h5A);
		send_item(ACT_EOF, 8'h00);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: write_dnl_enable(1'b1);
				1: write_dnl_enable(1'b0);
				2: write_dnl_enable(1'b1);
				default: write_dnl_enable(1'($urandom));
			endcase
			idle_on = (ph < 5);
			if (ph == 2) hold_req = 1'b1;
			target = fed_items + PHASE_ITEMS;
			while (fed_items < target) begin
				random_segment();
				if (ph == 3 && fed_items >= target - PHASE_ITEMS / 2 && fed_items < target - 70)
					settle();
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/jrmr_pkg.sv
src/jrmr_front.sv
src/jrmr_queue.sv
src/jrmr_back.sv
src/jpeg_restart_marker_resync.sv
bench/tb_top.sv
